// ===== src/dvre_pkg.sv =====
// shared types and constants for the distance-vector route engine
package dvre_pkg;

    localparam int          MAX_NODES      = 16;
    localparam logic [13:0] UNREACH        = 14'd10000;
    localparam logic [1:0]  REG_NODE_COUNT = 2'd0;

    typedef enum logic [1:0] {
        OP_SET_LINK = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_RELAX    = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK_A,
        S_LINK_B,
        S_CLEAR,
        S_RELAX_RD,
        S_RELAX_WT,
        S_RELAX_UPD,
        S_QUERY_RD,
        S_QUERY_WT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the beat
        logic link_wr_ab;  // write link a->b
        logic link_wr_ba;  // write link b->a
        logic clr_wr;      // write one cleared route entry
        logic clr_step;
        logic scan_rd;     // read operands for current (i,j)
        logic scan_upd;    // apply relaxation for current (i,j)
        logic scan_step;
        logic q_rd;
        logic q_cap;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic relax_ok;
        logic link_ok;
    } t_sts;

endpackage

// ===== src/dvre_ctrl.sv =====
// controller state machine for the route engine
module dvre_ctrl
    import dvre_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_op    i_op,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy
);

    t_state r_state, n_state;
    t_op    r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SET_LINK;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) r_op <= i_op;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_LINK_A;
            end
            S_LINK_A: begin
                unique case (r_op)
                    OP_SET_LINK: n_state = i_sts.link_ok ? S_LINK_B : S_DONE;
                    OP_CLEAR:    n_state = S_CLEAR;
                    OP_RELAX:    n_state = i_sts.relax_ok ? S_RELAX_RD : S_DONE;
                    OP_QUERY:    n_state = S_QUERY_RD;
                    default:     n_state = S_DONE;
                endcase
            end
            S_LINK_B:    n_state = S_DONE;
            S_CLEAR:     if (i_sts.clr_last) n_state = S_DONE;
            S_RELAX_RD:  n_state = S_RELAX_WT;
            S_RELAX_WT:  n_state = S_RELAX_UPD;
            S_RELAX_UPD: n_state = i_sts.scan_last ? S_DONE : S_RELAX_RD;
            S_QUERY_RD:  n_state = S_QUERY_WT;
            S_QUERY_WT:  n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:      o_cmd.load = i_start;
            S_LINK_A:    o_cmd.link_wr_ab = (r_op == OP_SET_LINK) && i_sts.link_ok;
            S_LINK_B:    o_cmd.link_wr_ba = 1'b1;
            S_CLEAR: begin
                o_cmd.clr_wr   = 1'b1;
                o_cmd.clr_step = 1'b1;
            end
            S_RELAX_RD:  o_cmd.scan_rd = 1'b1;
            S_RELAX_WT:  ;
            S_RELAX_UPD: begin
                o_cmd.scan_upd  = 1'b1;
                o_cmd.scan_step = 1'b1;
            end
            S_QUERY_RD:  o_cmd.q_rd = 1'b1;
            S_QUERY_WT:  o_cmd.q_cap = 1'b1;
            S_DONE:      o_cmd.done = 1'b1;
            default:     ;
        endcase
    end

endmodule

// ===== src/dvre_dp.sv =====
// datapath: link memory, route row of the source, sweep counters
module dvre_dp
    import dvre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_node_a,
    input  logic [3:0]  i_node_b,
    input  logic [7:0]  i_link_weight,
    input  logic [4:0]  i_node_count,
    output t_sts        o_sts,
    output logic [13:0] o_path_cost,
    output logic [3:0]  o_first_hop,
    output logic        o_reachable,
    output logic        o_valid
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW = 2 * NW;

    logic [7:0]  r_link [DEPTH];
    logic [13:0] r_dist [DEPTH];
    logic [3:0]  r_hop  [DEPTH];

    logic [1:0]  r_op;
    logic [3:0]  r_a, r_b;
    logic [7:0]  r_w;
    logic [4:0]  r_n;          // active node count, clamped
    logic [NW:0] r_ci, r_cj, r_ck;
    logic [AW-1:0] r_clr;
    logic        r_clr_done;

    logic [7:0]  r_cost;
    logic [13:0] r_di, r_dj;
    logic [3:0]  r_hi;
    logic [13:0] r_qd;
    logic [3:0]  r_qh;
    logic        r_qok;

    logic [AW-1:0] r_init;
    logic          r_init_busy;

    logic [NW-1:0] w_i, w_j, w_src;
    logic [AW-1:0] w_lnk_i, w_row_i, w_row_j;
    logic [AW-1:0] w_q_addr, w_rb_addr;
    logic [14:0]   w_cand;
    logic [3:0]    w_new_hop;
    logic          w_a_ok, w_b_ok;
    logic [5:0]    w_ncl;

    assign w_a_ok = ({2'b0, r_a} < 6'(MAX_NODES));
    assign w_b_ok = ({2'b0, r_b} < 6'(MAX_NODES));
    assign w_i    = r_ci[NW-1:0];
    assign w_j    = r_cj[NW-1:0];
    assign w_src  = r_a[NW-1:0];
    assign w_lnk_i = {w_i, w_j};
    assign w_row_i = {w_src, w_i};
    assign w_row_j = {w_src, w_j};
    assign w_q_addr = {r_a[NW-1:0], r_b[NW-1:0]};
    // second distance read port is shared by the sweep and the query
    assign w_rb_addr = i_cmd.q_rd ? w_q_addr : w_row_j;

    // clamp node count
    always_comb begin
        w_ncl = {1'b0, i_node_count};
        if (i_node_count == 5'd0) w_ncl = 6'd1;
        else if ({1'b0, i_node_count} > 6'(MAX_NODES)) w_ncl = 6'(MAX_NODES);
    end

    assign o_sts.link_ok   = w_a_ok && w_b_ok;
    assign o_sts.relax_ok  = w_a_ok && ({1'b0, r_a} < r_n);
    assign o_sts.clr_last  = (r_clr == '1);
    assign o_sts.scan_last = ({1'b0, r_cj} + 6'd1 >= {1'b0, r_n})
                          && ({1'b0, r_ci} + 6'd1 >= {1'b0, r_n})
                          && ({1'b0, r_ck} + 6'd2 >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_a  <= i_node_a;
            r_b  <= i_node_b;
            r_w  <= i_link_weight;
            r_n  <= w_ncl[4:0];
        end
    end

    // sweep counters: j fastest, then i, then k
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ci <= '0; r_cj <= '0; r_ck <= '0; r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end else if (i_cmd.scan_step) begin
            if ({1'b0, r_cj} + 6'd1 >= {1'b0, r_n}) begin
                r_cj <= '0;
                if ({1'b0, r_ci} + 6'd1 >= {1'b0, r_n}) begin
                    r_ci <= '0;
                    r_ck <= r_ck + 1'b1;
                end else begin
                    r_ci <= r_ci + 1'b1;
                end
            end else begin
                r_cj <= r_cj + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_done <= 1'b0;
        else r_clr_done <= 1'b1;
    end

    // candidate path through i
    assign w_cand = {1'b0, r_di} + {7'b0, r_cost};
    assign w_new_hop = (w_i == w_src) ? 4'(w_j) : r_hi;

    // link memory
    always_ff @(posedge i_clk) begin
        if (r_init_busy) begin
            r_link[r_init] <= 8'd0;
        end else begin
            if (i_cmd.link_wr_ab) r_link[w_q_addr] <= r_w;
            if (i_cmd.link_wr_ba) r_link[{r_b[NW-1:0], r_a[NW-1:0]}] <= r_w;
        end
        if (i_cmd.scan_rd) r_cost <= r_link[w_lnk_i];
    end

    // route memories: one write port, reads registered
    logic          w_rt_we;
    logic [AW-1:0] w_rt_wa;
    logic [13:0]   w_rt_wd;
    logic [3:0]    w_rt_wh;
    logic          w_upd_hop, w_upd_dist;

    always_comb begin
        w_upd_hop  = 1'b0;
        w_upd_dist = 1'b0;
        if (r_cost != 8'd0 && r_di != UNREACH && w_cand < 15'(UNREACH)) begin
            if (w_cand[13:0] == r_dj && w_i < w_j) w_upd_hop = 1'b1;
            else if (w_cand[13:0] < r_dj) w_upd_dist = 1'b1;
        end
    end

    always_comb begin
        w_rt_we = 1'b0;
        w_rt_wa = w_row_j;
        w_rt_wd = w_cand[13:0];
        w_rt_wh = w_new_hop;
        if (i_cmd.clr_wr) begin
            w_rt_we = 1'b1;
            w_rt_wa = r_clr;
            w_rt_wd = (r_clr[AW-1:NW] == r_clr[NW-1:0]) ? 14'd0 : UNREACH;
            w_rt_wh = (r_clr[AW-1:NW] == r_clr[NW-1:0]) ? 4'(r_clr[NW-1:0]) : 4'd0;
        end else if (i_cmd.scan_upd) begin
            w_rt_we = w_upd_hop || w_upd_dist;
            w_rt_wd = w_upd_dist ? w_cand[13:0] : r_dj;
        end
    end

    // distance held in a register array; hop written alongside
    // route rows start in reset pattern via one-time reset writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_init_busy <= 1'b1;
        end else if (r_init_busy) begin
            r_init <= r_init + AW'(1);
            if (r_init == '1) r_init_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init_busy) begin
            r_dist[r_init] <= (r_init[AW-1:NW] == r_init[NW-1:0]) ? 14'd0 : UNREACH;
            r_hop[r_init]  <= (r_init[AW-1:NW] == r_init[NW-1:0]) ?
                              4'(r_init[NW-1:0]) : 4'd0;
        end else if (w_rt_we) begin
            r_dist[w_rt_wa] <= w_rt_wd;
            r_hop[w_rt_wa]  <= w_rt_wh;
        end
        if (i_cmd.scan_rd) begin
            r_di <= r_dist[w_row_i];
            r_hi <= r_hop[w_row_i];
            r_dj <= r_dist[w_rb_addr];
        end
        if (i_cmd.q_rd) begin
            r_qd <= r_dist[w_rb_addr];
            r_qh <= r_hop[w_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_qok <= 1'b0;
        else if (i_cmd.q_cap) r_qok <= w_a_ok && w_b_ok;
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.done && r_clr_done;
        end
        if (i_cmd.done) begin
            if (r_op == 2'(OP_QUERY)) begin
                o_path_cost <= r_qok ? r_qd : UNREACH;
                o_reachable <= r_qok && (r_qd < UNREACH);
                o_first_hop <= (r_qok && r_qd < UNREACH) ? r_qh : 4'd0;
            end else begin
                o_path_cost <= 14'd0;
                o_reachable <= 1'b0;
                o_first_hop <= 4'd0;
            end
        end
    end

endmodule

// ===== src/distance_vector_route_engine_core.sv =====
// top level of the distance-vector route engine
// relax rate is set by the read, wait and compare-write loop on the route memory
// one item at a time; busy stays high until the result beat
// result beat lasts one cycle on o_valid, receiver cannot stall
// synchronous active-low reset; after reset an init pass over all MAX_NODES^2 entries initializes the tables
module distance_vector_route_engine_core
    import dvre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_node_a,
    input  logic [3:0]  i_node_b,
    input  logic [7:0]  i_link_weight,
    output logic        o_valid,
    output logic [13:0] o_path_cost,
    output logic [3:0]  o_first_hop,
    output logic        o_reachable,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_node_count;
    logic [8:0] r_boot;
    logic       w_busy_core;
    t_cmd       w_cmd;
    t_sts       w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 5'd16;
        end else if (psel && penable && pwrite && paddr == REG_NODE_COUNT) begin
            r_node_count <= pwdata[4:0];
        end
    end

    assign prdata = (paddr == REG_NODE_COUNT) ? {27'd0, r_node_count} : 32'd0;

    // table init pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 9'(MAX_NODES * MAX_NODES);
        else if (r_boot != 9'd0) r_boot <= r_boot - 9'd1;
    end

    assign busy = w_busy_core || (r_boot != 9'd0);

    dvre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_op    (t_op'(i_operation)),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy_core)
    );

    dvre_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (i_operation),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_link_weight (i_link_weight),
        .i_node_count  (r_node_count),
        .o_sts         (w_sts),
        .o_path_cost   (o_path_cost),
        .o_first_hop   (o_first_hop),
        .o_reachable   (o_reachable),
        .o_valid       (o_valid)
    );

endmodule
